// ----- hw/rtl/abrr_pkg.sv -----
// ---------------------------------------------------------------------------
// abrr_pkg
// Shared sizes, opcodes, status codes and register indexes of the audio
// block ring recorder.
// ---------------------------------------------------------------------------
package abrr_pkg;

    localparam int BLOCK_BYTES     = 512;
    localparam int WORDS_PER_BLOCK = BLOCK_BYTES / 2;
    localparam int WORD_AW         = $clog2(WORDS_PER_BLOCK);
    localparam int FILL_W          = $clog2(WORDS_PER_BLOCK + 1);
    localparam int BLOCK_SHIFT     = $clog2(BLOCK_BYTES);

    localparam int MAX_RING_BLOCKS = 1048576;
    localparam int RING_W          = $clog2(MAX_RING_BLOCKS + 1);
    localparam int INDEX_W         = $clog2(MAX_RING_BLOCKS);
    localparam int MOD_CNT_W       = $clog2(RING_W);

    localparam int ADDR_W   = 32;
    localparam int COUNT_W  = 32;
    localparam int SAMPLE_W = 16;
    localparam int OPCODE_W = 3;
    localparam int STATUS_W = 4;

    localparam logic [ADDR_W-1:0] BASE_RESET = 32'd32768;
    localparam logic [RING_W-1:0] RING_RESET = 21'd1024;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_BLOCK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CARD_BLOCK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_BLOCKS = 2'd2;

    // Opcodes.
    localparam logic [OPCODE_W-1:0] OP_ARM        = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_SAMPLE     = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_FINALIZE   = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_WRITE_OK   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_WRITE_FAIL = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_SNAP_READ  = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_WORD_READ  = 3'd6;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_ACCEPTED     = 4'd0;
    localparam logic [STATUS_W-1:0] ST_FLUSH_REQ    = 4'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_READY    = 4'd2;
    localparam logic [STATUS_W-1:0] ST_FLUSH_DONE   = 4'd3;
    localparam logic [STATUS_W-1:0] ST_WRITE_FAILED = 4'd4;
    localparam logic [STATUS_W-1:0] ST_READ_REQ     = 4'd5;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 4'd6;
    localparam logic [STATUS_W-1:0] ST_WORD         = 4'd7;
    localparam logic [STATUS_W-1:0] ST_IGNORED      = 4'd8;
    localparam logic [STATUS_W-1:0] ST_BUSY         = 4'd9;

endpackage

// ----- hw/rtl/abrr_if.sv -----
// ---------------------------------------------------------------------------
// abrr_in_if / abrr_out_if
// Valid/ready channels carrying one command word in and one result word out.
// ---------------------------------------------------------------------------
interface abrr_in_if;
    import abrr_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic signed [SAMPLE_W-1:0] sample;
    logic [INDEX_W-1:0]         item_index;

    modport source (output valid, opcode, sample, item_index, input ready);
    modport sink   (input valid, opcode, sample, item_index, output ready);
endinterface

interface abrr_out_if;
    import abrr_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   card_address;
    logic [SAMPLE_W-1:0] pending_word;
    logic [RING_W-1:0]   snapshot_blocks;
    logic                wrapped;
    logic [COUNT_W-1:0]  wrap_total;
    logic [COUNT_W-1:0]  failure_total;

    modport source (output valid, status, card_address, pending_word, snapshot_blocks,
                    wrapped, wrap_total, failure_total, input ready);
    modport sink   (input valid, status, card_address, pending_word, snapshot_blocks,
                    wrapped, wrap_total, failure_total, output ready);
endinterface

// ----- hw/rtl/audio_block_ring_recorder_core.sv -----
// A command word goes from idle to a finish state that loads its result word
// into the output register; a pending word read first passes a RAM read state,
// and a flush or snapshot read request first waits on a bit-serial remainder unit.
// Words are taken only in idle; the next word is taken while a result word
// waits at the output. Synchronous active-low reset disarms the recorder,
// clears all counters and loads the register reset values.
// ---------------------------------------------------------------------------
// audio_block_ring_recorder_core
// Packs samples into a pending block RAM, requests card block writes into a
// circular ring and maps snapshot indexes to oldest-first card addresses.
// ---------------------------------------------------------------------------
module audio_block_ring_recorder_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [abrr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [abrr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    abrr_in_if.sink                          i_item,
    abrr_out_if.source                       o_res
);
    import abrr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    // Configuration registers.
    logic [ADDR_W-1:0]   r_base;
    logic                r_card_blk;
    logic [RING_W-1:0]   r_ring_blocks;

    // Recorder state.
    logic [1:0]          r_state;
    logic [FILL_W-1:0]   r_fill;
    logic [FILL_W-1:0]   r_mark;
    logic                r_outst;
    logic [INDEX_W-1:0]  r_ring_idx;
    logic [RING_W-1:0]   r_written;
    logic [COUNT_W-1:0]  r_wrap_cnt;
    logic [COUNT_W-1:0]  r_fail_cnt;
    logic                r_armed;

    // Result being formed.
    logic [STATUS_W-1:0] r_res_status;
    logic                r_res_addr_en;
    logic [SAMPLE_W-1:0] r_res_word;
    logic                r_res_wrapped;
    logic [WORD_AW-1:0]  r_rd_idx;

    // Output register.
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [ADDR_W-1:0]   r_out_addr;
    logic [SAMPLE_W-1:0] r_out_word;
    logic [RING_W-1:0]   r_out_snap;
    logic                r_out_wrapped;
    logic [COUNT_W-1:0]  r_out_wrap_total;
    logic [COUNT_W-1:0]  r_out_fail_total;

    logic [STATUS_W-1:0] n_res_status;
    logic                n_res_addr_en;
    logic                n_res_wrapped;
    logic [1:0]          w_acc_state;

    logic                w_acc;
    logic                w_out_free;
    logic                w_out_load;
    logic [RING_W-1:0]   w_ring_size;
    logic [RING_W-1:0]   w_avail_blocks;
    logic [RING_W-1:0]   w_ring_inc;
    logic [INDEX_W-1:0]  w_oldest;
    logic [RING_W-1:0]   w_snap_sum;
    logic [FILL_W-1:0]   w_fill_next;
    logic                w_sample_flush;
    logic                w_ready_ok;
    logic                w_snap_in_range;
    logic                w_flush_go;
    logic                w_snap_go;
    logic                w_ram_we;
    logic [SAMPLE_W-1:0] w_rdata;
    logic                w_mod_start;
    logic [RING_W-1:0]   w_mod_dvd;
    logic                w_mod_done;
    logic [INDEX_W-1:0]  w_mod_rem;
    logic [ADDR_W-1:0]   w_blk;
    logic [ADDR_W-1:0]   w_card_addr;

    assign w_acc      = i_item.valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_out_load = (r_state == S_FIN) && w_out_free;

    // A ring size of zero counts as one; oversized rings are clamped.
    always_comb begin
        if (r_ring_blocks == '0) begin
            w_ring_size = RING_W'(1);
        end else if (r_ring_blocks > RING_W'(MAX_RING_BLOCKS)) begin
            w_ring_size = RING_W'(MAX_RING_BLOCKS);
        end else begin
            w_ring_size = r_ring_blocks;
        end
    end

    assign w_avail_blocks = (r_written < w_ring_size) ? r_written : w_ring_size;
    assign w_ring_inc     = {1'b0, r_ring_idx} + RING_W'(1);
    assign w_oldest       = (r_written >= w_ring_size) ? r_ring_idx : '0;
    assign w_snap_sum     = {1'b0, w_oldest} + {1'b0, i_item.item_index};

    assign w_fill_next    = (r_fill < FILL_W'(WORDS_PER_BLOCK)) ? (r_fill + 1'b1) : r_fill;
    assign w_sample_flush = (w_fill_next >= FILL_W'(WORDS_PER_BLOCK));
    assign w_ready_ok     = r_armed && !r_outst;
    assign w_snap_in_range = ({1'b0, i_item.item_index} < w_avail_blocks);

    assign w_flush_go = w_acc && w_ready_ok &&
                        (((i_item.opcode == OP_SAMPLE) && w_sample_flush) ||
                         ((i_item.opcode == OP_FINALIZE) && (r_fill != '0)));
    assign w_snap_go  = w_acc && w_ready_ok && (i_item.opcode == OP_SNAP_READ) &&
                        w_snap_in_range;

    assign w_mod_start = w_flush_go || w_snap_go;
    assign w_mod_dvd   = w_snap_go ? w_snap_sum : {1'b0, r_ring_idx};

    assign w_ram_we = w_acc && w_ready_ok && (i_item.opcode == OP_SAMPLE) &&
                      (r_fill < FILL_W'(WORDS_PER_BLOCK));

    // Result fields and follow-up state for the command word on the input.
    always_comb begin
        n_res_status  = ST_IGNORED;
        n_res_addr_en = 1'b0;
        n_res_wrapped = 1'b0;
        w_acc_state   = S_FIN;
        case (i_item.opcode)
            OP_ARM: begin
                n_res_status = ST_ACCEPTED;
            end
            OP_SAMPLE: begin
                if (!r_armed) begin
                    n_res_status = ST_NOT_READY;
                end else if (r_outst) begin
                    n_res_status = ST_BUSY;
                end else if (w_sample_flush) begin
                    n_res_status  = ST_FLUSH_REQ;
                    n_res_addr_en = 1'b1;
                    w_acc_state   = S_DIV;
                end else begin
                    n_res_status = ST_ACCEPTED;
                end
            end
            OP_FINALIZE: begin
                if (!r_armed) begin
                    n_res_status = ST_NOT_READY;
                end else if (r_outst) begin
                    n_res_status = ST_BUSY;
                end else if (r_fill == '0) begin
                    n_res_status = ST_FLUSH_DONE;
                end else begin
                    n_res_status  = ST_FLUSH_REQ;
                    n_res_addr_en = 1'b1;
                    w_acc_state   = S_DIV;
                end
            end
            OP_WRITE_OK: begin
                if (r_outst) begin
                    n_res_status  = ST_FLUSH_DONE;
                    n_res_wrapped = (w_ring_inc >= w_ring_size);
                end
            end
            OP_WRITE_FAIL: begin
                if (r_outst) begin
                    n_res_status = ST_WRITE_FAILED;
                end
            end
            OP_SNAP_READ: begin
                if (!r_armed) begin
                    n_res_status = ST_NOT_READY;
                end else if (r_outst) begin
                    n_res_status = ST_BUSY;
                end else if (!w_snap_in_range) begin
                    n_res_status = ST_OUT_OF_RANGE;
                end else begin
                    n_res_status  = ST_READ_REQ;
                    n_res_addr_en = 1'b1;
                    w_acc_state   = S_DIV;
                end
            end
            OP_WORD_READ: begin
                if (i_item.item_index >= INDEX_W'(WORDS_PER_BLOCK)) begin
                    n_res_status = ST_OUT_OF_RANGE;
                end else begin
                    n_res_status = ST_WORD;
                    w_acc_state  = S_READ;
                end
            end
            default: ;
        endcase
    end

    abrr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WORDS_PER_BLOCK)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_fill[WORD_AW-1:0]),
        .i_wdata (i_item.sample),
        .i_raddr (i_item.item_index[WORD_AW-1:0]),
        .o_rdata (w_rdata)
    );

    abrr_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (w_mod_dvd),
        .i_divisor  (w_ring_size),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    // Byte-addressed cards take the block number scaled by the block size.
    assign w_blk       = r_base + ADDR_W'(w_mod_rem);
    assign w_card_addr = r_card_blk ? w_blk : (w_blk << BLOCK_SHIFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base        <= BASE_RESET;
            r_card_blk    <= 1'b0;
            r_ring_blocks <= RING_RESET;
            r_state       <= S_IDLE;
            r_fill        <= '0;
            r_mark        <= '0;
            r_outst       <= 1'b0;
            r_ring_idx    <= '0;
            r_written     <= '0;
            r_wrap_cnt    <= '0;
            r_fail_cnt    <= '0;
            r_armed       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BASE_BLOCK:  r_base        <= i_cfg_data[ADDR_W-1:0];
                    CFG_CARD_BLOCK:  r_card_blk    <= i_cfg_data[0];
                    CFG_RING_BLOCKS: r_ring_blocks <= i_cfg_data[RING_W-1:0];
                    default: ;
                endcase
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_res_status  <= n_res_status;
                        r_res_addr_en <= n_res_addr_en;
                        r_res_word    <= '0;
                        r_res_wrapped <= n_res_wrapped;
                        r_state       <= w_acc_state;
                        case (i_item.opcode)
                            OP_ARM: begin
                                r_fill     <= '0;
                                r_mark     <= '0;
                                r_outst    <= 1'b0;
                                r_ring_idx <= '0;
                                r_written  <= '0;
                                r_wrap_cnt <= '0;
                                r_fail_cnt <= '0;
                                r_armed    <= 1'b1;
                            end
                            OP_SAMPLE: begin
                                if (w_ready_ok) begin
                                    r_fill <= w_fill_next;
                                    r_mark <= w_fill_next;
                                    if (w_sample_flush) begin
                                        r_outst <= 1'b1;
                                    end
                                end
                            end
                            OP_FINALIZE: begin
                                if (w_ready_ok && (r_fill != '0)) begin
                                    // The data mark stays put, so the padding reads as zero.
                                    r_fill  <= FILL_W'(WORDS_PER_BLOCK);
                                    r_outst <= 1'b1;
                                end
                            end
                            OP_WRITE_OK: begin
                                if (r_outst) begin
                                    r_outst <= 1'b0;
                                    r_fill  <= '0;
                                    r_mark  <= '0;
                                    if (w_ring_inc >= w_ring_size) begin
                                        r_ring_idx <= '0;
                                        r_wrap_cnt <= r_wrap_cnt + 1'b1;
                                    end else begin
                                        r_ring_idx <= w_ring_inc[INDEX_W-1:0];
                                    end
                                    if (r_written < w_ring_size) begin
                                        r_written <= r_written + 1'b1;
                                    end
                                end
                            end
                            OP_WRITE_FAIL: begin
                                if (r_outst) begin
                                    r_outst    <= 1'b0;
                                    r_armed    <= 1'b0;
                                    r_fail_cnt <= r_fail_cnt + 1'b1;
                                end
                            end
                            OP_WORD_READ: begin
                                r_rd_idx <= i_item.item_index[WORD_AW-1:0];
                            end
                            default: ;
                        endcase
                    end
                end
                S_READ: begin
                    r_res_word <= ({1'b0, r_rd_idx} < r_mark) ? w_rdata : '0;
                    r_state    <= S_FIN;
                end
                S_DIV: begin
                    if (w_mod_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_status     <= r_res_status;
                        r_out_addr       <= r_res_addr_en ? w_card_addr : '0;
                        r_out_word       <= r_res_word;
                        r_out_snap       <= r_armed ? w_avail_blocks : '0;
                        r_out_wrapped    <= r_res_wrapped;
                        r_out_wrap_total <= r_wrap_cnt;
                        r_out_fail_total <= r_fail_cnt;
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_item.ready          = (r_state == S_IDLE);
    assign o_res.valid           = r_out_valid;
    assign o_res.status          = r_out_status;
    assign o_res.card_address    = r_out_addr;
    assign o_res.pending_word    = r_out_word;
    assign o_res.snapshot_blocks = r_out_snap;
    assign o_res.wrapped         = r_out_wrapped;
    assign o_res.wrap_total      = r_out_wrap_total;
    assign o_res.failure_total   = r_out_fail_total;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= FILL_W'(WORDS_PER_BLOCK)) && (r_mark <= r_fill))
        else $error("fill or data mark out of bounds");

    a_outst_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outst |-> (r_fill == FILL_W'(WORDS_PER_BLOCK)))
        else $error("flush outstanding with a partial block");

    a_mod_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_done |-> (r_state == S_DIV))
        else $error("remainder finished outside the wait state");

    a_start_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_start |=> (r_state == S_DIV))
        else $error("remainder started without entering the wait state");

endmodule

// ----- hw/rtl/abrr_ram.sv -----
// ---------------------------------------------------------------------------
// abrr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module abrr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/abrr_mod.sv -----
// ---------------------------------------------------------------------------
// abrr_mod
// Restoring remainder unit: one dividend bit per cycle, done pulses once the
// last bit has been shifted in. The remainder holds until the next start.
// ---------------------------------------------------------------------------
module abrr_mod (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [abrr_pkg::RING_W-1:0]    i_dividend,
    input  logic [abrr_pkg::RING_W-1:0]    i_divisor,
    output logic                           o_done,
    output logic [abrr_pkg::INDEX_W-1:0]   o_rem
);
    import abrr_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [MOD_CNT_W-1:0] r_cnt;
    logic [RING_W-1:0]    r_dvd;
    logic [RING_W-1:0]    r_div;
    logic [INDEX_W-1:0]   r_rem;

    logic [RING_W-1:0]    w_trial;
    logic [RING_W-1:0]    w_next;

    // The remainder stays below the divisor, which never exceeds 2^INDEX_W,
    // so the trial value fits in RING_W bits.
    assign w_trial = {r_rem, r_dvd[RING_W-1]};
    assign w_next  = (w_trial >= r_div) ? (w_trial - r_div) : w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == MOD_CNT_W'(RING_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= w_next[INDEX_W-1:0];
                r_dvd <= {r_dvd[RING_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MOD_CNT_W'(RING_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- dv/tb_audio_block_ring_recorder_core.sv -----
// ---------------------------------------------------------------------------
// tb_audio_block_ring_recorder_core
// Self-checking bench for the ring recorder core. It walks a short directed
// table, then runs random command words over several register settings. An
// in-bench recorder model predicts each result word, and a monitor checks
// every field of every result in order. Both channels see random stalls.
// ---------------------------------------------------------------------------
module tb_audio_block_ring_recorder_core;
    import abrr_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;
    localparam int DRAIN_CYCLES = 30;
    localparam int PRINT_MAX    = 40;

    typedef struct {
        logic [OPCODE_W-1:0] opcode;
        logic [SAMPLE_W-1:0] sample;
        logic [INDEX_W-1:0]  item_index;
        bit                  has_status;
        logic [STATUS_W-1:0] status;
    } cmd_row_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   card_address;
        logic [SAMPLE_W-1:0] pending_word;
        logic [RING_W-1:0]   snapshot_blocks;
        logic                wrapped;
        logic [COUNT_W-1:0]  wrap_total;
        logic [COUNT_W-1:0]  failure_total;
    } rec_result_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    abrr_in_if  item_if ();
    abrr_out_if res_if ();

    audio_block_ring_recorder_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_if),
        .o_res      (res_if)
    );

    // Recorder model state.
    logic [ADDR_W-1:0]   rec_base;
    logic                rec_card_blk;
    logic [RING_W-1:0]   rec_ring_cfg;
    logic [SAMPLE_W-1:0] rec_store [WORDS_PER_BLOCK];
    int unsigned         rec_fill;
    int unsigned         rec_mark;
    bit                  rec_flush_pending;
    int unsigned         rec_ring_idx;
    int unsigned         rec_written;
    logic [COUNT_W-1:0]  rec_wraps;
    logic [COUNT_W-1:0]  rec_fails;
    bit                  rec_armed;

    rec_result_t due_results [$];
    cmd_row_t    dir_rows [$];
    int          err_count;
    int          result_count;
    bit          src_calm;
    bit          snk_calm;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic int unsigned ring_size_now();
        int unsigned r;
        r = rec_ring_cfg;
        if (r == 0) r = 1;
        if (r > MAX_RING_BLOCKS) r = MAX_RING_BLOCKS;
        return r;
    endfunction

    function automatic int unsigned avail_blocks();
        int unsigned r;
        r = ring_size_now();
        return (rec_written < r) ? rec_written : r;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_for(int unsigned rel);
        logic [ADDR_W-1:0] blk;
        blk = rec_base + ADDR_W'(rel);
        return rec_card_blk ? blk : (blk << BLOCK_SHIFT);
    endfunction

    // Advances the recorder model by one command word and returns its result.
    function automatic rec_result_t recorder_step(logic [OPCODE_W-1:0] op,
                                                  logic [SAMPLE_W-1:0] smp,
                                                  logic [INDEX_W-1:0] idx);
        rec_result_t       res;
        int unsigned       r;
        int unsigned       oldest;
        longint unsigned   rel;
        r = ring_size_now();
        res.status = ST_IGNORED;
        res.card_address = '0;
        res.pending_word = '0;
        res.wrapped = 1'b0;
        case (op)
            OP_ARM: begin
                rec_fill = 0;
                rec_mark = 0;
                rec_flush_pending = 0;
                rec_ring_idx = 0;
                rec_written = 0;
                rec_wraps = '0;
                rec_fails = '0;
                rec_armed = 1;
                res.status = ST_ACCEPTED;
            end
            OP_SAMPLE, OP_FINALIZE: begin
                if (!rec_armed) begin
                    res.status = ST_NOT_READY;
                end else if (rec_flush_pending) begin
                    res.status = ST_BUSY;
                end else if (op == OP_SAMPLE) begin
                    if (rec_fill < WORDS_PER_BLOCK) begin
                        rec_store[rec_fill] = smp;
                        rec_fill++;
                        rec_mark = rec_fill;
                    end
                    res.status = ST_ACCEPTED;
                    if (rec_fill >= WORDS_PER_BLOCK) begin
                        rec_flush_pending = 1;
                        res.card_address = addr_for(rec_ring_idx % r);
                        res.status = ST_FLUSH_REQ;
                    end
                end else if (rec_fill == 0) begin
                    res.status = ST_FLUSH_DONE;
                end else begin
                    // Padding only moves the fill mark; the data mark stays put.
                    rec_fill = WORDS_PER_BLOCK;
                    rec_flush_pending = 1;
                    res.card_address = addr_for(rec_ring_idx % r);
                    res.status = ST_FLUSH_REQ;
                end
            end
            OP_WRITE_OK: begin
                if (rec_flush_pending) begin
                    rec_flush_pending = 0;
                    rec_fill = 0;
                    rec_mark = 0;
                    if (rec_ring_idx + 1 >= r) begin
                        rec_ring_idx = 0;
                        rec_wraps++;
                        res.wrapped = 1'b1;
                    end else begin
                        rec_ring_idx++;
                    end
                    if (rec_written < r) rec_written++;
                    res.status = ST_FLUSH_DONE;
                end
            end
            OP_WRITE_FAIL: begin
                if (rec_flush_pending) begin
                    rec_flush_pending = 0;
                    rec_armed = 0;
                    rec_fails++;
                    res.status = ST_WRITE_FAILED;
                end
            end
            OP_SNAP_READ: begin
                if (!rec_armed) begin
                    res.status = ST_NOT_READY;
                end else if (rec_flush_pending) begin
                    res.status = ST_BUSY;
                end else if (idx >= avail_blocks()) begin
                    res.status = ST_OUT_OF_RANGE;
                end else begin
                    oldest = (rec_written >= r) ? rec_ring_idx : 0;
                    rel = (longint'(oldest) + idx) % r;
                    res.card_address = addr_for(int'(rel));
                    res.status = ST_READ_REQ;
                end
            end
            OP_WORD_READ: begin
                if (idx >= WORDS_PER_BLOCK) begin
                    res.status = ST_OUT_OF_RANGE;
                end else begin
                    res.pending_word = (idx < rec_mark) ? rec_store[idx] : '0;
                    res.status = ST_WORD;
                end
            end
            default: res.status = ST_IGNORED;
        endcase
        res.snapshot_blocks = rec_armed ? RING_W'(avail_blocks()) : '0;
        res.wrap_total = rec_wraps;
        res.failure_total = rec_fails;
        return res;
    endfunction

    // Mostly short gaps, a few long ones, none at all while calm.
    function automatic int pick_idle(bit calm);
        int p;
        p = $urandom_range(0, 99);
        if (calm || p < 60) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_row(logic [OPCODE_W-1:0] op, logic [SAMPLE_W-1:0] smp,
                                    logic [INDEX_W-1:0] idx, bit has_st,
                                    logic [STATUS_W-1:0] st);
        dir_rows.push_back('{op, smp, idx, has_st, st});
    endfunction

    task automatic report_mismatch(string field, longint unsigned exp_v,
                                   longint unsigned got_v);
        err_count++;
        if (err_count <= PRINT_MAX)
            $display("MISMATCH result word %0d, %s: expected %0h, got %0h",
                     result_count, field, exp_v, got_v);
    endtask

    task automatic send_word(logic [OPCODE_W-1:0] op, logic [SAMPLE_W-1:0] smp,
                             logic [INDEX_W-1:0] idx, bit has_st,
                             logic [STATUS_W-1:0] st);
        int          gap;
        rec_result_t exp_res;
        if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
        gap = pick_idle(src_calm);
        @(negedge i_clk);
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_if.valid      <= 1'b1;
        item_if.opcode     <= op;
        item_if.sample     <= smp;
        item_if.item_index <= idx;
        do @(posedge i_clk); while (item_if.ready !== 1'b1);
        exp_res = recorder_step(op, smp, idx);
        if (has_st) exp_res.status = st;
        due_results.push_back(exp_res);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        item_if.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_BASE_BLOCK:  rec_base = data;
            CFG_CARD_BLOCK:  rec_card_blk = data[0];
            CFG_RING_BLOCKS: rec_ring_cfg = data[RING_W-1:0];
            default: ;
        endcase
    endtask

    // Random word shaped by the model state: well-formed recording most of the
    // time, with stray commands mixed in.
    task automatic pick_random(int sample_pct, output logic [OPCODE_W-1:0] op,
                               output logic [SAMPLE_W-1:0] smp,
                               output logic [INDEX_W-1:0] idx);
        int          p;
        int unsigned vb;
        p   = $urandom_range(0, 99);
        smp = SAMPLE_W'($urandom);
        idx = INDEX_W'($urandom_range(0, WORDS_PER_BLOCK - 1));
        vb  = avail_blocks();
        if (rec_flush_pending) begin
            if (p < 70) op = OP_WRITE_OK;
            else if (p < 82) op = OP_WRITE_FAIL;
            else op = OPCODE_W'($urandom_range(0, 7));
        end else if (!rec_armed) begin
            op = (p < 65) ? OP_ARM : OPCODE_W'($urandom_range(0, 7));
        end else if (p < sample_pct) begin
            op = OP_SAMPLE;
        end else begin
            p = $urandom_range(0, 99);
            if (p < 30) op = OP_FINALIZE;
            else if (p < 55) op = OP_SNAP_READ;
            else if (p < 80) op = OP_WORD_READ;
            else if (p < 85) op = OP_ARM;
            else if (p < 90) op = OP_UNUSED;
            else if (p < 95) op = OP_WRITE_OK;
            else op = OP_WRITE_FAIL;
        end
        if (op == OP_SNAP_READ) begin
            p = $urandom_range(0, 9);
            if (p < 7 && vb > 0) idx = INDEX_W'($urandom_range(0, vb - 1));
            else if (p < 9) idx = INDEX_W'(vb);
            else idx = INDEX_W'($urandom);
        end else if (op == OP_WORD_READ && $urandom_range(0, 7) == 0) begin
            idx = INDEX_W'($urandom);
        end
    endtask

    task automatic run_phase(logic [ADDR_W-1:0] base, logic card_blk,
                             logic [RING_W-1:0] ring, int n_words, int sample_pct);
        logic [OPCODE_W-1:0] op;
        logic [SAMPLE_W-1:0] smp;
        logic [INDEX_W-1:0]  idx;
        wait_idle();
        write_reg(CFG_BASE_BLOCK, base);
        write_reg(CFG_CARD_BLOCK, CFG_DATA_W'(card_blk));
        write_reg(CFG_RING_BLOCKS, CFG_DATA_W'(ring));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        repeat (n_words) begin
            pick_random(sample_pct, op, smp, idx);
            send_word(op, smp, idx, 1'b0, ST_IGNORED);
        end
    endtask

    // Result side: random stalls on ready.
    initial begin
        int stall_left;
        stall_left   = 0;
        res_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else begin
                res_if.ready <= 1'b1;
                if ($urandom_range(0, 39) == 0) snk_calm = !snk_calm;
                stall_left = pick_idle(snk_calm);
            end
        end
    end

    always @(posedge i_clk) begin
        rec_result_t exp_res;
        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            result_count++;
            if (due_results.size() == 0) begin
                report_mismatch("word with nothing expected, status", 0, res_if.status);
            end else begin
                exp_res = due_results.pop_front();
                if (res_if.status !== exp_res.status)
                    report_mismatch("status", exp_res.status, res_if.status);
                if (res_if.card_address !== exp_res.card_address)
                    report_mismatch("card_address", exp_res.card_address,
                                    res_if.card_address);
                if (res_if.pending_word !== exp_res.pending_word)
                    report_mismatch("pending_word", exp_res.pending_word,
                                    res_if.pending_word);
                if (res_if.snapshot_blocks !== exp_res.snapshot_blocks)
                    report_mismatch("snapshot_blocks", exp_res.snapshot_blocks,
                                    res_if.snapshot_blocks);
                if (res_if.wrapped !== exp_res.wrapped)
                    report_mismatch("wrapped", exp_res.wrapped, res_if.wrapped);
                if (res_if.wrap_total !== exp_res.wrap_total)
                    report_mismatch("wrap_total", exp_res.wrap_total, res_if.wrap_total);
                if (res_if.failure_total !== exp_res.failure_total)
                    report_mismatch("failure_total", exp_res.failure_total,
                                    res_if.failure_total);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = CFG_BASE_BLOCK;
        i_cfg_data         = '0;
        item_if.valid      = 1'b0;
        item_if.opcode     = OP_ARM;
        item_if.sample     = '0;
        item_if.item_index = '0;
        err_count          = 0;
        result_count       = 0;
        src_calm           = 1'b0;
        snk_calm           = 1'b0;

        rec_base          = BASE_RESET;
        rec_card_blk      = 1'b0;
        rec_ring_cfg      = RING_RESET;
        rec_fill          = 0;
        rec_mark          = 0;
        rec_flush_pending = 0;
        rec_ring_idx      = 0;
        rec_written       = 0;
        rec_wraps         = '0;
        rec_fails         = '0;
        rec_armed         = 0;
        foreach (rec_store[i]) rec_store[i] = '0;

        // Directed part, from reset with the reset register values.
        add_row(OP_SAMPLE,     16'h7FFF, '0, 1, ST_NOT_READY);
        add_row(OP_FINALIZE,   '0,       '0, 1, ST_NOT_READY);
        add_row(OP_SNAP_READ,  '0,       '0, 1, ST_NOT_READY);
        add_row(OP_WRITE_OK,   '0,       '0, 1, ST_IGNORED);
        add_row(OP_WRITE_FAIL, '0,       '0, 1, ST_IGNORED);
        add_row(OP_WORD_READ,  '0,       '0, 1, ST_WORD);
        add_row(OP_WORD_READ,  '0, INDEX_W'(WORDS_PER_BLOCK), 1, ST_OUT_OF_RANGE);
        add_row(OP_WORD_READ,  '0,       20'hFFFFF, 1, ST_OUT_OF_RANGE);
        add_row(OP_UNUSED,     16'hFFFF, 20'hFFFFF, 1, ST_IGNORED);
        add_row(OP_ARM,        '0,       '0, 1, ST_ACCEPTED);
        add_row(OP_FINALIZE,   '0,       '0, 1, ST_FLUSH_DONE);
        add_row(OP_SNAP_READ,  '0,       '0, 1, ST_OUT_OF_RANGE);
        add_row(OP_SAMPLE,     16'h8000, '0, 1, ST_ACCEPTED);
        add_row(OP_SAMPLE,     16'h7FFF, '0, 1, ST_ACCEPTED);
        add_row(OP_WORD_READ,  '0,       20'd1, 0, ST_IGNORED);
        add_row(OP_WORD_READ,  '0,       20'd255, 1, ST_WORD);
        add_row(OP_FINALIZE,   '0,       '0, 1, ST_FLUSH_REQ);
        add_row(OP_SAMPLE,     16'h1234, '0, 1, ST_BUSY);
        add_row(OP_SNAP_READ,  '0,       '0, 1, ST_BUSY);
        add_row(OP_WORD_READ,  '0,       20'd0, 0, ST_IGNORED);
        add_row(OP_WRITE_OK,   '0,       '0, 1, ST_FLUSH_DONE);
        add_row(OP_SNAP_READ,  '0,       '0, 0, ST_IGNORED);
        add_row(OP_SNAP_READ,  '0,       20'd1, 1, ST_OUT_OF_RANGE);
        add_row(OP_SAMPLE,     16'hFFFF, '0, 1, ST_ACCEPTED);
        add_row(OP_FINALIZE,   '0,       '0, 1, ST_FLUSH_REQ);
        add_row(OP_WRITE_FAIL, '0,       '0, 1, ST_WRITE_FAILED);
        add_row(OP_SAMPLE,     16'h0001, '0, 1, ST_NOT_READY);
        add_row(OP_WORD_READ,  '0,       20'd0, 0, ST_IGNORED);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_word(dir_rows[i].opcode, dir_rows[i].sample, dir_rows[i].item_index,
                      dir_rows[i].has_status, dir_rows[i].status);

        // Random part over several ring settings. Shrinking the ring without
        // re-arming leaves the ring index beyond the ring. The last phase sends only
        // samples while armed with no flush pending, so whole blocks fill up word by word.
        run_phase(BASE_RESET,       1'b0, RING_RESET,   60, 60);
        run_phase(32'hFFFF_FFFF,    1'b1, 21'd1,        60, 60);
        run_phase(32'hFFFF_FFF0,    1'b0, 21'd3,        50, 60);
        run_phase(ADDR_W'($urandom), 1'b1, 21'd0,       40, 60);
        run_phase(ADDR_W'($urandom), 1'b0, 21'h1F_FFFF, 40, 60);
        run_phase(ADDR_W'($urandom), 1'b1, 21'd5,       60, 50);
        run_phase(ADDR_W'($urandom), 1'b1, 21'd2,       50, 50);
        run_phase(32'h0000_0000,    1'b0, RING_W'(MAX_RING_BLOCKS), 280, 100);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
